@@ rtl/mplmc_pkg.sv @@
// Package with shared types and constants for the multi-pattern line match counter.
package mplmc_pkg;

  // Default configuration of the pattern set.
  localparam int NUM_PATTERNS_DEF = 6;
  localparam int MAX_LEN_DEF      = 128;

  // Field widths fixed by the item format.
  localparam int REQ_W   = 2;
  localparam int SEL_W   = 3;
  localparam int POS_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 7;
  localparam int MASK_W  = 6;
  localparam int CNT_W   = 32;
  localparam int LPOS_W  = 8;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [LPOS_W-1:0] LPOS_MAX     = 8'hFF;
  localparam logic [CNT_W-1:0]  COUNT_MAX    = 32'hFFFF_FFFF;

  // Request kinds carried by the req_type field.
  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_BYTE = 2'd0,
    REQ_SET_LEN   = 2'd1,
    REQ_TEXT_BYTE = 2'd2,
    REQ_READ_CNT  = 2'd3
  } req_type_t;

endpackage

@@ rtl/multi_pattern_line_match_counter_top.sv @@
// Top level of the multi-pattern exact line match counter.
// Each result is registered in the output register when its item is accepted. Throughput:
// one item per cycle while out_ready takes results; the per-pattern byte memories prefetch
// the byte at the next line position, so a text byte is compared the cycle it arrives.
// Reset (synchronous, active low) clears lengths, counters, line position and the output
// valid, and sets every still-matching flag. Pattern bytes are undefined until loaded.
module multi_pattern_line_match_counter_top
  import mplmc_pkg::*;
#(
  parameter int NUM_PATTERNS = NUM_PATTERNS_DEF,
  parameter int MAX_LEN      = MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [SEL_W-1:0]  in_pattern_sel,
  input  logic [POS_W-1:0]  in_position,
  input  logic [BYTE_W-1:0] in_byte_value,
  input  logic [LEN_W-1:0]  in_length_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_line_done,
  output logic [MASK_W-1:0] out_match_mask,
  output logic              out_count_valid,
  output logic [CNT_W-1:0]  out_count_value
);

  // Address width of one pattern memory, and a mask width that covers both the
  // pattern count and the reported mask.
  localparam int AW = $clog2(MAX_LEN);
  localparam int MW = (NUM_PATTERNS > MASK_W) ? NUM_PATTERNS : MASK_W;

  // Line tracking state.
  logic [LPOS_W-1:0]       line_pos_r, line_pos_nxt;
  logic [NUM_PATTERNS-1:0] still_r, still_nxt;

  // Per-pattern lengths and saturating hit counters.
  logic [LEN_W-1:0] len_r   [NUM_PATTERNS];
  logic [LEN_W-1:0] len_nxt [NUM_PATTERNS];
  logic [CNT_W-1:0] cnt_r   [NUM_PATTERNS];
  logic [CNT_W-1:0] cnt_nxt [NUM_PATTERNS];

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic              line_done_r;
  logic [MASK_W-1:0] match_mask_r;
  logic              count_valid_r;
  logic [CNT_W-1:0]  count_value_r;

  // Decoded item.
  logic                    in_accept;
  logic                    is_load, is_len, is_text, is_read, is_newline;
  logic [NUM_PATTERNS-1:0] sel_dec;
  logic                    sel_ok;
  logic                    load_pos_ok;
  logic                    lpos_in_store;
  logic [NUM_PATTERNS-1:0] bank_we;
  logic [NUM_PATTERNS-1:0] keep_vec;
  logic [NUM_PATTERNS-1:0] hit_vec;
  logic [MW-1:0]           hit_wide;
  logic [CNT_W-1:0]        cnt_sel;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           rd_addr;

  // The output register frees up whenever its item is taken, so a new item
  // can enter in the same cycle that the previous result leaves.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  assign is_load    = in_req_type == REQ_LOAD_BYTE;
  assign is_len     = in_req_type == REQ_SET_LEN;
  assign is_text    = in_req_type == REQ_TEXT_BYTE;
  assign is_read    = in_req_type == REQ_READ_CNT;
  assign is_newline = is_text && (in_byte_value == NEWLINE_BYTE);

  // One-hot pattern select; a select beyond the pattern count decodes to nothing.
  always_comb begin
    for (int i = 0; i < NUM_PATTERNS; i++) begin
      sel_dec[i] = 32'(in_pattern_sel) == 32'(i);
    end
  end
  assign sel_ok = |sel_dec;

  assign load_pos_ok   = 32'(in_position) < 32'(MAX_LEN);
  assign lpos_in_store = 32'(line_pos_r) < 32'(MAX_LEN);
  assign bank_we       = (in_accept && is_load && load_pos_ok) ? sel_dec : '0;
  assign wr_addr       = AW'(in_position);

  // The memories are always read at the position the next text byte will
  // land on, so the byte is already registered when that item arrives.
  assign rd_addr = rst_n ? AW'(line_pos_nxt) : '0;

  // One byte memory per pattern, all read at the same line position.
  for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_bank
    logic [BYTE_W-1:0] pat_mem [MAX_LEN];
    logic [BYTE_W-1:0] rd_data_r;

    always_ff @(posedge clk) begin
      if (bank_we[g]) begin
        pat_mem[wr_addr] <= in_byte_value;
      end
      // A load to the address being prefetched is passed straight through.
      if (bank_we[g] && (wr_addr == rd_addr)) begin
        rd_data_r <= in_byte_value;
      end else begin
        rd_data_r <= pat_mem[rd_addr];
      end
    end

    // A text byte keeps the pattern alive only inside its length and store.
    assign keep_vec[g] = (line_pos_r < {1'b0, len_r[g]}) && lpos_in_store &&
                         (rd_data_r == in_byte_value);
    assign hit_vec[g]  = still_r[g] && (line_pos_r == {1'b0, len_r[g]});
  end

  assign hit_wide = MW'(hit_vec);

  // Counter read mux.
  always_comb begin
    cnt_sel = '0;
    for (int i = 0; i < NUM_PATTERNS; i++) begin
      if (sel_dec[i]) begin
        cnt_sel = cnt_r[i];
      end
    end
  end

  // Next state of the line tracker, the lengths and the counters.
  always_comb begin
    line_pos_nxt = line_pos_r;
    still_nxt    = still_r;
    for (int i = 0; i < NUM_PATTERNS; i++) begin
      len_nxt[i] = len_r[i];
      cnt_nxt[i] = cnt_r[i];
    end
    if (in_accept) begin
      if (is_load || is_len) begin
        // Changing a pattern in the middle of a line rules it out for that line.
        // A load outside the store changes nothing and so rules nothing out.
        if ((line_pos_r != '0) && (is_len || load_pos_ok)) begin
          still_nxt = still_r & ~sel_dec;
        end
        if (is_len) begin
          for (int i = 0; i < NUM_PATTERNS; i++) begin
            if (sel_dec[i]) begin
              len_nxt[i] = in_length_value;
              cnt_nxt[i] = '0;
            end
          end
        end
      end else if (is_newline) begin
        for (int i = 0; i < NUM_PATTERNS; i++) begin
          if (hit_vec[i] && (cnt_r[i] != COUNT_MAX)) begin
            cnt_nxt[i] = cnt_r[i] + 1'b1;
          end
        end
        still_nxt    = '1;
        line_pos_nxt = '0;
      end else if (is_text) begin
        still_nxt = still_r & keep_vec;
        if (line_pos_r != LPOS_MAX) begin
          line_pos_nxt = line_pos_r + 1'b1;
        end
      end
    end
  end

  // Output register handshake: set on accept, cleared once the item is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pos_r  <= '0;
      still_r     <= '1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        len_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      line_pos_r  <= line_pos_nxt;
      still_r     <= still_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        len_r[i] <= len_nxt[i];
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  // Result payload; fields that do not apply to the item are zero.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      line_done_r   <= is_newline;
      match_mask_r  <= is_newline ? hit_wide[MASK_W-1:0] : '0;
      count_valid_r <= is_read && sel_ok;
      count_value_r <= (is_read && sel_ok) ? cnt_sel : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_line_done   = line_done_r;
  assign out_match_mask  = match_mask_r;
  assign out_count_valid = count_valid_r;
  assign out_count_value = count_value_r;

  // A result never answers both a line end and a counter read.
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(line_done_r && count_valid_r))
    else $error("result flags both a line end and a counter read");

  // Only a line end may report matches.
  a_mask_only_on_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !line_done_r) |-> (match_mask_r == '0))
    else $error("match mask set on an item that did not end a line");

  // A newline restarts the line tracker.
  a_newline_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && is_newline) |=> ((line_pos_r == '0) && (&still_r)))
    else $error("line tracker not restarted after a newline");

  // Outside a line end the counter of pattern 0 does not move up; it only holds or is cleared.
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_accept && is_newline) |=> (cnt_r[0] == $past(cnt_r[0])) || (cnt_r[0] == '0))
    else $error("counter changed without a line end");

endmodule
